/* design/sphrc_pkg.sv */
// ---------------------------------------------------------------------------
// Sphere/rectangle contact package
// Shared types, codes and helpers for the contact pipeline.
// ---------------------------------------------------------------------------
package sphrc_pkg;

   // Contact classification codes.
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_FACE   = 2'd1,
      KIND_CORNER = 2'd2,
      KIND_EDGE   = 2'd3
   } kind_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ORIGIN_X      = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y      = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z      = 3'd2;
   localparam logic [2:0] CSR_AXIS_FIRST    = 3'd3;
   localparam logic [2:0] CSR_AXIS_SECOND   = 3'd4;
   localparam logic [2:0] CSR_AXIS_NORMAL   = 3'd5;
   localparam logic [2:0] CSR_LENGTH_FIRST  = 3'd6;
   localparam logic [2:0] CSR_LENGTH_SECOND = 3'd7;

   // Reset values of the axis registers (x, y, z packed high to low).
   localparam logic [53:0] AXIS_FIRST_RST  = {18'h10000, 36'h0};
   localparam logic [53:0] AXIS_SECOND_RST = {18'h0, 18'h10000, 18'h0};
   localparam logic [53:0] AXIS_NORMAL_RST = {36'h0, 18'h10000};
   localparam logic [30:0] LENGTH_RST      = 31'h10000;

   // Limits of the normal and arm results.
   localparam logic signed [18:0] NORM_MAX = 19'sd65536;
   localparam logic signed [26:0] ARM_MAX  = 27'sd16777215;

   // Pipeline depths.
   localparam int ROOT_W    = 24;
   localparam int QUO_W     = 17;

   // Wall description as held in the configuration registers.
   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [53:0]        axis_first;
      logic [53:0]        axis_second;
      logic [53:0]        axis_normal;
      logic [30:0]        length_first;
      logic [30:0]        length_second;
   } cfg_type;

   // Per-item side information that rides along the pipeline.
   typedef struct packed {
      kind_type           kind;
      logic [23:0]        radius;
      logic [23:0]        abs_wz;
      logic signed [17:0] face_nx;
      logic signed [17:0] face_ny;
      logic signed [17:0] face_nz;
   } side_type;

   // Side information plus the normal numerators, carried through the root.
   typedef struct packed {
      side_type           side;
      logic signed [44:0] num_x;
      logic signed [44:0] num_y;
      logic signed [44:0] num_z;
   } sq_side_type;

   // One signed Q2.16 component of a packed axis; index 0 is x.
   function automatic logic signed [17:0] axis_comp(input logic [53:0] axis,
                                                    input int unsigned idx);
      axis_comp = axis[53 - 18 * idx -: 18];
   endfunction

endpackage

/* design/sphere_rectangle_contact.sv */
// ---------------------------------------------------------------------------
// Sphere/rectangle contact
// Contact test of a sphere against a rectangular wall: kind, depth, normal
// and contact arm for every sphere word.
// ---------------------------------------------------------------------------
// The block takes one sphere word per clock cycle unless the output stalls, and
// returns one result word per sphere word, in order. The chain of units holds
// six stages of projection and region tests, a 24-stage square root that yields
// one bit of the distance per stage, a 19-stage divider that scales the three
// normal components, and two stages for the contact arm. The whole pipeline
// advances together; it holds while a result word waits at the output and
// req_tready is low only then. The user must write the wall registers through
// the csr port only while no word is in flight; the block does not enforce it.
module sphere_rectangle_contact (
   input  logic          clock,
   input  logic          reset,
   // Sphere words.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [119:0]  req_tdata,  // centre_x, centre_y, centre_z, radius
   // Result words.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [159:0]  rsp_tdata,  // depth, normal_x/y/z, arm_x/y/z, zero fill
   output logic [2:0]    rsp_tuser,  // in_contact, contact_kind
   // Wall registers.
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [53:0]   csr_wdata
);

   logic                   adv;
   sphrc_pkg::cfg_type     cfg;

   logic signed [31:0]     origin_x_ff, origin_y_ff, origin_z_ff;
   logic [53:0]            axis_first_ff, axis_second_ff, axis_normal_ff;
   logic [30:0]            length_first_ff, length_second_ff;

   logic                   fr_valid;
   logic [47:0]            fr_sum;
   sphrc_pkg::sq_side_type fr_side;

   logic                   sq_valid;
   logic [23:0]            sq_root;
   sphrc_pkg::sq_side_type sq_side;

   logic                   dv_valid;
   logic [23:0]            dv_h;
   sphrc_pkg::side_type    dv_side;
   logic signed [17:0]     dv_norm [3];

   logic [23:0]            dep_in;
   logic [24:0]            fac_in;
   logic signed [17:0]     nrm_sel [3];
   logic signed [43:0]     prod_in [3];

   logic                   a_vld_ff;
   sphrc_pkg::kind_type    a_kind_ff;
   logic [23:0]            a_dep_ff;
   logic signed [17:0]     a_nrm_ff [3];
   logic signed [43:0]     a_prod_ff [3];

   logic signed [43:0]     rnd [3];
   logic signed [26:0]     arm_full [3];
   logic signed [24:0]     arm_in [3];

   logic                   rsp_tvalid_ff;
   logic [159:0]           rsp_tdata_ff;
   logic [2:0]             rsp_tuser_ff;

   // The pipeline moves unless a finished word is stalled at the output.
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // Wall registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         origin_z_ff      <= '0;
         axis_first_ff    <= sphrc_pkg::AXIS_FIRST_RST;
         axis_second_ff   <= sphrc_pkg::AXIS_SECOND_RST;
         axis_normal_ff   <= sphrc_pkg::AXIS_NORMAL_RST;
         length_first_ff  <= sphrc_pkg::LENGTH_RST;
         length_second_ff <= sphrc_pkg::LENGTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            sphrc_pkg::CSR_ORIGIN_X:      origin_x_ff      <= csr_wdata[31:0];
            sphrc_pkg::CSR_ORIGIN_Y:      origin_y_ff      <= csr_wdata[31:0];
            sphrc_pkg::CSR_ORIGIN_Z:      origin_z_ff      <= csr_wdata[31:0];
            sphrc_pkg::CSR_AXIS_FIRST:    axis_first_ff    <= csr_wdata;
            sphrc_pkg::CSR_AXIS_SECOND:   axis_second_ff   <= csr_wdata;
            sphrc_pkg::CSR_AXIS_NORMAL:   axis_normal_ff   <= csr_wdata;
            sphrc_pkg::CSR_LENGTH_FIRST:  length_first_ff  <= csr_wdata[30:0];
            sphrc_pkg::CSR_LENGTH_SECOND: length_second_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign cfg.origin_x      = origin_x_ff;
   assign cfg.origin_y      = origin_y_ff;
   assign cfg.origin_z      = origin_z_ff;
   assign cfg.axis_first    = axis_first_ff;
   assign cfg.axis_second   = axis_second_ff;
   assign cfg.axis_normal   = axis_normal_ff;
   assign cfg.length_first  = length_first_ff;
   assign cfg.length_second = length_second_ff;

   sphrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .centre_x  (req_tdata[31:0]),
      .centre_y  (req_tdata[63:32]),
      .centre_z  (req_tdata[95:64]),
      .radius    (req_tdata[119:96]),
      .cfg       (cfg),
      .out_valid (fr_valid),
      .out_sum   (fr_sum),
      .out_side  (fr_side)
   );

   sphrc_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .valid_i (fr_valid),
      .x_i     (fr_sum),
      .side_i  (fr_side),
      .valid_o (sq_valid),
      .root_o  (sq_root),
      .side_o  (sq_side)
   );

   sphrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .valid_i  (sq_valid),
      .h_i      (sq_root),
      .side_i   (sq_side),
      .valid_o  (dv_valid),
      .h_o      (dv_h),
      .side_o   (dv_side),
      .norm_x_o (dv_norm[0]),
      .norm_y_o (dv_norm[1]),
      .norm_z_o (dv_norm[2])
   );

   // Depth, arm factor (radius + distance) and normal per contact kind.
   always_comb begin
      case (dv_side.kind)
         sphrc_pkg::KIND_FACE: begin
            dep_in     = dv_side.radius - dv_side.abs_wz;
            fac_in     = 25'(dv_side.radius) + 25'(dv_side.abs_wz);
            nrm_sel[0] = dv_side.face_nx;
            nrm_sel[1] = dv_side.face_ny;
            nrm_sel[2] = dv_side.face_nz;
         end
         sphrc_pkg::KIND_CORNER, sphrc_pkg::KIND_EDGE: begin
            dep_in     = dv_side.radius - dv_h;
            fac_in     = 25'(dv_side.radius) + 25'(dv_h);
            nrm_sel[0] = dv_norm[0];
            nrm_sel[1] = dv_norm[1];
            nrm_sel[2] = dv_norm[2];
         end
         default: begin
            dep_in     = '0;
            fac_in     = '0;
            nrm_sel[0] = '0;
            nrm_sel[1] = '0;
            nrm_sel[2] = '0;
         end
      endcase
      for (int j = 0; j < 3; j++) prod_in[j] = $signed({1'b0, fac_in}) * nrm_sel[j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_kind_ff <= dv_side.kind;
         a_dep_ff  <= dep_in;
         for (int j = 0; j < 3; j++) begin
            a_nrm_ff[j]  <= nrm_sel[j];
            a_prod_ff[j] <= prod_in[j];
         end
      end
   end

   // Arm: round half up by 2^17 and clamp.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         rnd[j]      = a_prod_ff[j] + 44'sd65536;
         arm_full[j] = rnd[j][43:17];
         if (arm_full[j] > sphrc_pkg::ARM_MAX) begin
            arm_in[j] = 25'(sphrc_pkg::ARM_MAX);
         end else if (arm_full[j] < -sphrc_pkg::ARM_MAX) begin
            arm_in[j] = 25'(-sphrc_pkg::ARM_MAX);
         end else begin
            arm_in[j] = arm_full[j][24:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tuser_ff <= {a_kind_ff, a_kind_ff != sphrc_pkg::KIND_NONE};
         rsp_tdata_ff <= {7'b0, arm_in[2], arm_in[1], arm_in[0],
                          a_nrm_ff[2], a_nrm_ff[1], a_nrm_ff[0], a_dep_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A word without contact carries all-zero results.
   a_no_contact_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0 && rsp_tuser[2:1] == '0))
      else $error("no-contact word carries nonzero fields");

   // A contact always has some depth.
   a_contact_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[23:0] != '0))
      else $error("contact with zero depth");

   // The x and z normal components stay within one.
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[41:24]) <= 18'sd65536
                      && $signed(rsp_tdata[41:24]) >= -18'sd65536
                      && $signed(rsp_tdata[77:60]) <= 18'sd65536
                      && $signed(rsp_tdata[77:60]) >= -18'sd65536))
      else $error("normal out of range");

   // A stalled output word stays valid and unchanged.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && !$fell(rsp_tvalid)))
      else $error("stalled output word changed");

endmodule

/* design/sphrc_front.sv */
// ---------------------------------------------------------------------------
// Sphere/rectangle contact front end
// Projects the centre onto the wall axes, classifies the region and forms the
// squared distance and the normal numerators. Six register stages.
// ---------------------------------------------------------------------------
module sphrc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic signed [31:0]    centre_x,
   input  logic signed [31:0]    centre_y,
   input  logic signed [31:0]    centre_z,
   input  logic [23:0]           radius,
   input  sphrc_pkg::cfg_type    cfg,
   output logic                  out_valid,
   output logic [47:0]           out_sum,
   output sphrc_pkg::sq_side_type out_side
);

   logic               vld_ff [6];

   logic signed [17:0] ax [3][3];

   // Stage 1 state.
   logic signed [32:0] dp_ff [3];
   logic [23:0]        r1_ff;
   // Stage 2 state.
   logic signed [50:0] p_ff [3][3];
   logic [23:0]        r2_ff;
   // Stage 3 state.
   logic signed [52:0] acc [3];
   logic signed [36:0] w_in [3];
   logic signed [36:0] w_ff [3];
   logic [23:0]        r3_ff;
   // Stage 4 state.
   logic signed [36:0] l1s, l2s, d0, d1;
   logic [36:0]        ad0, ad1, awz;
   logic               in_x, in_y, lo_x, hi_x, lo_y, hi_y;
   logic               face_in, small_in;
   sphrc_pkg::kind_type cand_in;
   logic signed [18:0] fc [3];
   logic signed [17:0] fn_in [3];
   logic               face4_ff, small4_ff;
   sphrc_pkg::kind_type cand4_ff;
   logic signed [24:0] d_ff [3];
   logic [23:0]        awz4_ff;
   logic signed [17:0] fn4_ff [3];
   logic [23:0]        r4_ff;
   // Stage 5 state.
   logic signed [49:0] sqf [3];
   logic [47:0]        sq_ff [3];
   logic [47:0]        rr_ff;
   logic signed [42:0] np_ff [3][3];
   logic               face5_ff, small5_ff;
   sphrc_pkg::kind_type cand5_ff;
   logic [23:0]        awz5_ff;
   logic signed [17:0] fn5_ff [3];
   logic [23:0]        r5_ff;
   // Stage 6 logic.
   logic [49:0]        sum;
   logic               hit;
   sphrc_pkg::kind_type kind_in;
   logic signed [44:0] num_in [3];
   logic [47:0]        sum_ff;
   sphrc_pkg::sq_side_type side_in, side_ff;

   // Axis components of the three wall axes.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ax[0][j] = sphrc_pkg::axis_comp(cfg.axis_first, j);
         ax[1][j] = sphrc_pkg::axis_comp(cfg.axis_second, j);
         ax[2][j] = sphrc_pkg::axis_comp(cfg.axis_normal, j);
      end
   end

   // Valid bits travel with the words.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 6; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int s = 1; s < 6; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   // Stage 1: offset from the wall corner.
   always_ff @(posedge clock) begin
      if (adv) begin
         dp_ff[0] <= {centre_x[31], centre_x} - {cfg.origin_x[31], cfg.origin_x};
         dp_ff[1] <= {centre_y[31], centre_y} - {cfg.origin_y[31], cfg.origin_y};
         dp_ff[2] <= {centre_z[31], centre_z} - {cfg.origin_z[31], cfg.origin_z};
         r1_ff    <= radius;
      end
   end

   // Stage 2: the nine products of the projection.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) p_ff[i][j] <= dp_ff[j] * ax[i][j];
         end
         r2_ff <= r1_ff;
      end
   end

   // Stage 3: dot products rounded to Q16.16, ties up.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i]  = 53'(p_ff[i][0]) + 53'(p_ff[i][1]) + 53'(p_ff[i][2]) + 53'sd32768;
         w_in[i] = acc[i][52:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) w_ff[i] <= w_in[i];
         r3_ff <= r2_ff;
      end
   end

   // Stage 4: region tests, offsets from the nearest corner or edge.
   always_comb begin
      l1s  = 37'(cfg.length_first);
      l2s  = 37'(cfg.length_second);
      in_x = (w_ff[0] > 0) && (w_ff[0] < l1s);
      in_y = (w_ff[1] > 0) && (w_ff[1] < l2s);
      lo_x = w_ff[0] < 0;
      hi_x = w_ff[0] > l1s;
      lo_y = w_ff[1] < 0;
      hi_y = w_ff[1] > l2s;
      awz  = w_ff[2][36] ? 37'(-w_ff[2]) : 37'(w_ff[2]);
      face_in = in_x && in_y && (awz < 37'(r3_ff));

      cand_in = sphrc_pkg::KIND_NONE;
      d0 = '0;
      d1 = '0;
      if ((lo_x || hi_x) && (lo_y || hi_y)) begin
         cand_in = sphrc_pkg::KIND_CORNER;
         d0 = lo_x ? w_ff[0] : w_ff[0] - l1s;
         d1 = lo_y ? w_ff[1] : w_ff[1] - l2s;
      end else if (in_x && (lo_y || hi_y)) begin
         cand_in = sphrc_pkg::KIND_EDGE;
         d1 = lo_y ? w_ff[1] : w_ff[1] - l2s;
      end else if (in_y && (lo_x || hi_x)) begin
         cand_in = sphrc_pkg::KIND_EDGE;
         d0 = lo_x ? w_ff[0] : w_ff[0] - l1s;
      end
      ad0 = d0[36] ? 37'(-d0) : 37'(d0);
      ad1 = d1[36] ? 37'(-d1) : 37'(d1);
      small_in = (ad0 < 37'(r3_ff)) && (ad1 < 37'(r3_ff)) && (awz < 37'(r3_ff));

      // Face normal points against the side the centre lies on.
      for (int j = 0; j < 3; j++) begin
         if (w_ff[2] > 0) begin
            fc[j] = -19'(ax[2][j]);
         end else if (w_ff[2] < 0) begin
            fc[j] = 19'(ax[2][j]);
         end else begin
            fc[j] = '0;
         end
         if (fc[j] > sphrc_pkg::NORM_MAX) begin
            fn_in[j] = 18'(sphrc_pkg::NORM_MAX);
         end else if (fc[j] < -sphrc_pkg::NORM_MAX) begin
            fn_in[j] = 18'(-sphrc_pkg::NORM_MAX);
         end else begin
            fn_in[j] = fc[j][17:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         face4_ff  <= face_in;
         small4_ff <= small_in;
         cand4_ff  <= cand_in;
         d_ff[0]   <= d0[24:0];
         d_ff[1]   <= d1[24:0];
         d_ff[2]   <= w_ff[2][24:0];
         awz4_ff   <= awz[23:0];
         for (int j = 0; j < 3; j++) fn4_ff[j] <= fn_in[j];
         r4_ff     <= r3_ff;
      end
   end

   // Stage 5: squares, radius squared and the numerator products.
   always_comb begin
      for (int i = 0; i < 3; i++) sqf[i] = d_ff[i] * d_ff[i];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sqf[i][47:0];
            for (int j = 0; j < 3; j++) np_ff[j][i] <= d_ff[i] * ax[i][j];
         end
         rr_ff     <= r4_ff * r4_ff;
         face5_ff  <= face4_ff;
         small5_ff <= small4_ff;
         cand5_ff  <= cand4_ff;
         awz5_ff   <= awz4_ff;
         for (int j = 0; j < 3; j++) fn5_ff[j] <= fn4_ff[j];
         r5_ff     <= r4_ff;
      end
   end

   // Stage 6: distance test, final kind and negated numerators.
   always_comb begin
      sum = 50'(sq_ff[0]) + 50'(sq_ff[1]) + 50'(sq_ff[2]);
      hit = (cand5_ff != sphrc_pkg::KIND_NONE) && small5_ff && (sum < 50'(rr_ff));
      if (face5_ff) begin
         kind_in = sphrc_pkg::KIND_FACE;
      end else if (hit) begin
         kind_in = cand5_ff;
      end else begin
         kind_in = sphrc_pkg::KIND_NONE;
      end
      for (int j = 0; j < 3; j++) begin
         num_in[j] = -(45'(np_ff[j][0]) + 45'(np_ff[j][1]) + 45'(np_ff[j][2]));
      end
      side_in.side.kind    = kind_in;
      side_in.side.radius  = r5_ff;
      side_in.side.abs_wz  = awz5_ff;
      side_in.side.face_nx = fn5_ff[0];
      side_in.side.face_ny = fn5_ff[1];
      side_in.side.face_nz = fn5_ff[2];
      side_in.num_x        = num_in[0];
      side_in.num_y        = num_in[1];
      side_in.num_z        = num_in[2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff  <= (hit && !face5_ff) ? sum[47:0] : '0;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_sum   = sum_ff;
   assign out_side  = side_ff;

endmodule

/* design/sphrc_sqrt.sv */
// ---------------------------------------------------------------------------
// Sphere/rectangle contact square root
// Pipelined integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module sphrc_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   valid_i,
   input  logic [47:0]            x_i,
   input  sphrc_pkg::sq_side_type side_i,
   output logic                   valid_o,
   output logic [23:0]            root_o,
   output sphrc_pkg::sq_side_type side_o
);

   localparam int STAGES = sphrc_pkg::ROOT_W;

   logic [47:0]            x_ff    [STAGES];
   logic [48:0]            rt_ff   [STAGES];
   logic                   vld_ff  [STAGES];
   sphrc_pkg::sq_side_type side_ff [STAGES];

   genvar k;
   for (k = 0; k < STAGES; k++) begin : g_step
      localparam logic [48:0] BIT = 49'(1) << (2 * (STAGES - 1 - k));

      logic [47:0]            x_cur, x_in;
      logic [48:0]            rt_cur, rt_in, trial;
      logic                   v_cur;
      sphrc_pkg::sq_side_type s_cur;

      if (k == 0) begin : g_first
         assign x_cur  = x_i;
         assign rt_cur = '0;
         assign v_cur  = valid_i;
         assign s_cur  = side_i;
      end else begin : g_rest
         assign x_cur  = x_ff[k-1];
         assign rt_cur = rt_ff[k-1];
         assign v_cur  = vld_ff[k-1];
         assign s_cur  = side_ff[k-1];
      end

      // One restoring step of the digit-by-digit root.
      always_comb begin
         trial = rt_cur + BIT;
         if ({1'b0, x_cur} >= trial) begin
            x_in  = x_cur - trial[47:0];
            rt_in = (rt_cur >> 1) + BIT;
         end else begin
            x_in  = x_cur;
            rt_in = rt_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[k]    <= x_in;
            rt_ff[k]   <= rt_in;
            side_ff[k] <= s_cur;
         end
      end
   end

   assign valid_o = vld_ff[STAGES-1];
   assign root_o  = rt_ff[STAGES-1][23:0];
   assign side_o  = side_ff[STAGES-1];

endmodule

/* design/sphrc_div.sv */
// ---------------------------------------------------------------------------
// Sphere/rectangle contact normal divider
// Three pipelined restoring dividers that scale the normal numerators by the
// distance, rounded to nearest and clamped to one.
// ---------------------------------------------------------------------------
module sphrc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   valid_i,
   input  logic [23:0]            h_i,
   input  sphrc_pkg::sq_side_type side_i,
   output logic                   valid_o,
   output logic [23:0]            h_o,
   output sphrc_pkg::side_type    side_o,
   output logic signed [17:0]     norm_x_o,
   output logic signed [17:0]     norm_y_o,
   output logic signed [17:0]     norm_z_o
);

   localparam int STEPS = sphrc_pkg::QUO_W;

   typedef struct packed {
      logic [45:0]      rem;
      logic [STEPS-1:0] quo;
      logic             sat;
      logic             neg;
   } lane_type;

   logic signed [44:0]  num [3];
   logic [44:0]         mag [3];
   logic [45:0]         numer [3];
   logic [24:0]         dv_in;
   lane_type            pre_in [3];

   lane_type            pr_lane_ff [3];
   logic [24:0]         pr_dv_ff;
   logic [23:0]         pr_h_ff;
   sphrc_pkg::side_type pr_side_ff;
   logic                pr_vld_ff;

   lane_type            st_lane_ff [STEPS][3];
   logic [24:0]         st_dv_ff   [STEPS];
   logic [23:0]         st_h_ff    [STEPS];
   sphrc_pkg::side_type st_side_ff [STEPS];
   logic                st_vld_ff  [STEPS];

   logic [17:0]         qmag [3];
   logic signed [17:0]  nrm_in [3];
   logic signed [17:0]  nrm_ff [3];
   logic [23:0]         h_ff;
   sphrc_pkg::side_type side_ff;
   logic                vld_ff;

   // Prepare: q = floor((2|n| + h) / 2h), with early saturation check.
   always_comb begin
      num[0] = side_i.num_x;
      num[1] = side_i.num_y;
      num[2] = side_i.num_z;
      dv_in  = {h_i, 1'b0};
      for (int j = 0; j < 3; j++) begin
         mag[j]        = num[j][44] ? 45'(-num[j]) : 45'(num[j]);
         numer[j]      = {mag[j], 1'b0} + 46'(h_i);
         pre_in[j].rem = numer[j];
         pre_in[j].quo = '0;
         pre_in[j].sat = numer[j] >= {4'b0, dv_in, 17'b0};
         pre_in[j].neg = num[j][44];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else if (adv) begin
         pr_vld_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) pr_lane_ff[j] <= pre_in[j];
         pr_dv_ff   <= dv_in;
         pr_h_ff    <= h_i;
         pr_side_ff <= side_i.side;
      end
   end

   // One quotient bit per stage, most significant first.
   genvar s;
   for (s = 0; s < STEPS; s++) begin : g_step
      localparam int K = STEPS - 1 - s;

      lane_type            l_cur [3];
      lane_type            l_in  [3];
      logic [24:0]         dv_cur;
      logic [23:0]         h_cur;
      sphrc_pkg::side_type sd_cur;
      logic                v_cur;
      logic [45:0]         shifted;

      if (s == 0) begin : g_first
         assign l_cur  = pr_lane_ff;
         assign dv_cur = pr_dv_ff;
         assign h_cur  = pr_h_ff;
         assign sd_cur = pr_side_ff;
         assign v_cur  = pr_vld_ff;
      end else begin : g_rest
         assign l_cur  = st_lane_ff[s-1];
         assign dv_cur = st_dv_ff[s-1];
         assign h_cur  = st_h_ff[s-1];
         assign sd_cur = st_side_ff[s-1];
         assign v_cur  = st_vld_ff[s-1];
      end

      always_comb begin
         shifted = 46'(dv_cur) << K;
         for (int j = 0; j < 3; j++) begin
            l_in[j] = l_cur[j];
            if (l_cur[j].rem >= shifted) begin
               l_in[j].rem    = l_cur[j].rem - shifted;
               l_in[j].quo[K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_vld_ff[s] <= 1'b0;
         end else if (adv) begin
            st_vld_ff[s] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int j = 0; j < 3; j++) st_lane_ff[s][j] <= l_in[j];
            st_dv_ff[s]   <= dv_cur;
            st_h_ff[s]    <= h_cur;
            st_side_ff[s] <= sd_cur;
         end
      end
   end

   // Finish: clamp to one, apply sign, zero for a zero distance.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         if (st_lane_ff[STEPS-1][j].sat
             || (18'(st_lane_ff[STEPS-1][j].quo) > 18'(sphrc_pkg::NORM_MAX))) begin
            qmag[j] = 18'(sphrc_pkg::NORM_MAX);
         end else begin
            qmag[j] = 18'(st_lane_ff[STEPS-1][j].quo);
         end
         if (st_h_ff[STEPS-1] == '0) begin
            nrm_in[j] = '0;
         end else if (st_lane_ff[STEPS-1][j].neg) begin
            nrm_in[j] = -$signed(qmag[j]);
         end else begin
            nrm_in[j] = $signed(qmag[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= st_vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) nrm_ff[j] <= nrm_in[j];
         h_ff    <= st_h_ff[STEPS-1];
         side_ff <= st_side_ff[STEPS-1];
      end
   end

   assign valid_o  = vld_ff;
   assign h_o      = h_ff;
   assign side_o   = side_ff;
   assign norm_x_o = nrm_ff[0];
   assign norm_y_o = nrm_ff[1];
   assign norm_z_o = nrm_ff[2];

endmodule
